### rtl/core/pcm_byte_stream_normalizer_defines.svh
// assertion macros for the pcm byte stream normalizer
// used by the top level; expects a clock named clock and a reset named reset
`ifndef PCM_BYTE_STREAM_NORMALIZER_DEFINES_SVH
`define PCM_BYTE_STREAM_NORMALIZER_DEFINES_SVH

// same-cycle implication
`define PCMBSN_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcmbsn: same-cycle check failed");

// next-cycle implication
`define PCMBSN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcmbsn: next-cycle check failed");

`endif

### rtl/core/pcmbsn_pkg.sv
// shared types and constants for the pcm byte stream normalizer
// no dependencies
package pcmbsn_pkg;

   typedef enum logic [1:0] {
      KIND_SIGNED   = 2'd0,
      KIND_UNSIGNED = 2'd1,
      KIND_FLOAT    = 2'd2,
      KIND_UNKNOWN  = 2'd3
   } kind_type;

   // register indexes on the csr port
   localparam logic [1:0] CSR_SAMPLE_BYTES = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_KIND  = 2'd1;
   localparam logic [1:0] CSR_BIG_ENDIAN   = 2'd2;

   // bytes-per-sample codes
   localparam logic [1:0] SIZE_8  = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_24 = 2'd2;
   localparam logic [1:0] SIZE_32 = 2'd3;

   localparam logic [1:0] RESET_SAMPLE_BYTES = SIZE_16;

   localparam logic [31:0] Q31_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q31_MIN = 32'h8000_0000;

   // float exponent landmarks
   localparam logic [7:0] EXP_ONE     = 8'd127;
   localparam logic [7:0] EXP_ALIGN   = 8'd119;
   localparam logic [7:0] EXP_SPECIAL = 8'hFF;

endpackage

### rtl/core/pcm_byte_stream_normalizer.sv
// The transfer of a sample's last byte loads the assembled sample register, and the
// result register loads from it when the result side is not stalled; rsp_valid rises with it.
// Throughput: one byte per cycle while req_stall is low; one gathering register and one conversion
// register, both advancing together whenever the result side is not stalled.
// Reset (synchronous, active high) sets 16-bit little-endian signed samples,
// clears the gathered bytes and empties both stages.
// depends on pcmbsn_pkg and pcm_byte_stream_normalizer_defines.svh
`include "pcm_byte_stream_normalizer_defines.svh"

module pcm_byte_stream_normalizer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_stream_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_norm_sample,
   output logic               rsp_clipped,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [1:0]         csr_wr_data
);
   import pcmbsn_pkg::*;

   // configuration
   logic [1:0] code_ff;
   kind_type   kind_ff;
   logic       big_ff;

   // gathering state
   logic [1:0]  byte_index_ff;
   logic [1:0]  byte_index_in;
   logic [23:0] partial_word_ff;
   logic [23:0] partial_word_in;

   // assembled sample stage
   logic        a_valid_ff;
   logic [31:0] a_raw_ff;
   logic [31:0] a_raw_in;
   logic [1:0]  a_code_ff;
   kind_type    a_kind_ff;
   logic [31:0] a_mag_ff;
   logic [31:0] a_mag_in;
   logic        a_neg_ff;
   logic        a_neg_in;

   // result stage
   logic        rsp_valid_ff;
   logic [31:0] norm_ff;
   logic [31:0] norm_in;
   logic        clip_ff;
   logic        clip_in;

   logic req_xfer;
   logic finish;
   logic en_a;
   logic en_b;
   logic load_a;
   logic at_rail;

   assign en_b      = !rsp_valid_ff || !rsp_stall;
   assign en_a      = !a_valid_ff || en_b;
   assign req_stall = !en_a;
   assign req_xfer  = req_valid && !req_stall;
   assign finish    = byte_index_ff >= code_ff;
   assign load_a    = req_xfer && finish && (kind_ff != KIND_UNKNOWN);

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= RESET_SAMPLE_BYTES;
         kind_ff <= KIND_SIGNED;
         big_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SAMPLE_BYTES: code_ff <= csr_wr_data;
            CSR_SAMPLE_KIND:  kind_ff <= kind_type'(csr_wr_data);
            CSR_BIG_ENDIAN:   big_ff  <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // byte gathering
   always_comb begin
      byte_index_in   = byte_index_ff;
      partial_word_in = partial_word_ff;
      if (req_xfer) begin
         if (finish) begin
            byte_index_in   = 2'd0;
            partial_word_in = 24'd0;
         end else begin
            byte_index_in = byte_index_ff + 2'd1;
            case (byte_index_ff)
               2'd0:    partial_word_in[7:0]   = req_stream_byte;
               2'd1:    partial_word_in[15:8]  = req_stream_byte;
               default: partial_word_in[23:16] = req_stream_byte;
            endcase
         end
      end
   end

   // sample assembly and the unsigned offset |2x - (2^n - 1)|
   always_comb begin
      logic [7:0]  gathered [4];
      logic [1:0]  pos;
      logic [1:0]  src;
      logic [32:0] twox;
      logic [32:0] full;
      gathered[0] = partial_word_ff[7:0];
      gathered[1] = partial_word_ff[15:8];
      gathered[2] = partial_word_ff[23:16];
      gathered[3] = req_stream_byte;
      gathered[code_ff] = req_stream_byte;
      a_raw_in = 32'd0;
      for (int p = 0; p < 4; p++) begin
         pos = 2'(p);
         src = big_ff ? (code_ff - pos) : pos;
         if (pos <= code_ff) begin
            a_raw_in[8*p +: 8] = gathered[src];
         end
      end
      case (code_ff)
         SIZE_8:  full = 33'h0_0000_00FF;
         SIZE_16: full = 33'h0_0000_FFFF;
         SIZE_24: full = 33'h0_00FF_FFFF;
         default: full = 33'h0_FFFF_FFFF;
      endcase
      twox     = {a_raw_in, 1'b0};
      a_neg_in = twox < full;
      a_mag_in = a_neg_in ? 32'(full - twox) : 32'(twox - full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff   <= 2'd0;
         partial_word_ff <= 24'd0;
         a_valid_ff      <= 1'b0;
      end else begin
         byte_index_ff   <= byte_index_in;
         partial_word_ff <= partial_word_in;
         if (en_a) begin
            a_valid_ff <= load_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a && load_a) begin
         a_raw_ff  <= a_raw_in;
         a_code_ff <= code_ff;
         a_kind_ff <= kind_ff;
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
      end
   end

   // conversion
   always_comb begin
      logic [31:0] rep;
      logic [32:0] q_round;
      logic [31:0] q;
      logic        f_sign;
      logic [7:0]  f_exp;
      logic [22:0] f_frac;
      logic [23:0] f_sig;
      logic [7:0]  f_shift;
      logic [31:0] f_mag;
      // the fraction m/(2^n-1) is m repeated; round on its 32nd bit
      case (a_code_ff)
         SIZE_8:  rep = {4{a_mag_ff[7:0]}};
         SIZE_16: rep = {2{a_mag_ff[15:0]}};
         SIZE_24: rep = {a_mag_ff[23:0], a_mag_ff[23:16]};
         default: rep = a_mag_ff;
      endcase
      q_round = {1'b0, rep} + 33'd1;
      q       = q_round[32:1];

      f_sign  = a_raw_ff[31];
      f_exp   = a_raw_ff[30:23];
      f_frac  = a_raw_ff[22:0];
      f_sig   = {1'b1, f_frac};
      f_shift = EXP_ALIGN - f_exp;
      if (f_exp >= EXP_ALIGN) begin
         f_mag = {8'd0, f_sig} << 3'(f_exp - EXP_ALIGN);
      end else if (f_shift >= 8'd24) begin
         f_mag = 32'd0;
      end else begin
         f_mag = {8'd0, f_sig >> 5'(f_shift)};
      end

      norm_in = 32'd0;
      clip_in = 1'b0;
      if (a_kind_ff == KIND_SIGNED) begin
         case (a_code_ff)
            SIZE_8:  norm_in = a_raw_ff << 24;
            SIZE_16: norm_in = a_raw_ff << 16;
            SIZE_24: norm_in = a_raw_ff << 8;
            default: norm_in = a_raw_ff;
         endcase
      end else if (a_kind_ff == KIND_FLOAT && a_code_ff == SIZE_32) begin
         if (f_exp == EXP_SPECIAL && f_frac != 23'd0) begin
            norm_in = 32'd0;
         end else if (f_exp == 8'd0) begin
            norm_in = 32'd0;
         end else if (f_exp >= EXP_ONE) begin
            if (f_sign && f_exp == EXP_ONE && f_frac == 23'd0) begin
               norm_in = Q31_MIN;
            end else begin
               clip_in = 1'b1;
               norm_in = f_sign ? Q31_MIN : Q31_MAX;
            end
         end else begin
            norm_in = f_sign ? (32'd0 - f_mag) : f_mag;
         end
      end else begin
         if (a_neg_ff) begin
            norm_in = 32'd0 - q;
         end else if (q[31]) begin
            clip_in = 1'b1;
            norm_in = Q31_MAX;
         end else begin
            norm_in = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_b) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b && a_valid_ff) begin
         norm_ff <= norm_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_norm_sample = signed'(norm_ff);
   assign rsp_clipped     = clip_ff;

   assign at_rail = (norm_ff == Q31_MAX) || (norm_ff == Q31_MIN);

   `PCMBSN_ASSERT_IMPLY(a_clip_is_rail, rsp_valid && rsp_clipped, at_rail)
   `PCMBSN_ASSERT_IMPLY(a_open_when_empty, !rsp_valid_ff, !req_stall)
   `PCMBSN_ASSERT_NEXT(a_sample_enters, load_a, a_valid_ff)
   `PCMBSN_ASSERT_NEXT(a_gather_clears, req_xfer && finish, byte_index_ff == 2'd0 && partial_word_ff == 24'd0)

endmodule

### test/pcmbsn_sample_checker.sv
// sample checker for the pcm byte stream normaliser: shadows the registers, gathers
// bytes, predicts each Q1.31 sample and compares it with every result transfer
// depends on pcmbsn_pkg
module pcmbsn_sample_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_stream_byte,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_norm_sample,
   input  logic               rsp_clipped,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [1:0]         csr_wr_data,
   output int                 mismatches,
   output int                 pending
);
   import pcmbsn_pkg::*;

   typedef struct packed {
      logic [31:0] sample;
      logic        clip;
   } norm_result_type;

   norm_result_type expected_samples[$];

   logic [1:0]  size_code;
   kind_type    kind;
   logic        big_end;
   logic [1:0]  held_count;
   logic [23:0] held_bytes;
   int          fail_count = 0;

   assign mismatches = fail_count;

   function automatic logic [31:0] unsigned_to_q31(input logic [31:0] raw, input int nbytes,
                                                   output logic clip);
      logic [63:0] span;
      logic [63:0] twice;
      logic [63:0] offset;
      logic [63:0] quot;
      logic        below;
      span  = (64'd1 << (8 * nbytes)) - 64'd1;
      twice = {32'd0, raw} << 1;
      if (twice >= span) begin
         offset = twice - span;
         below  = 1'b0;
      end else begin
         offset = span - twice;
         below  = 1'b1;
      end
      // span is odd, so adding half of it rounds to nearest with no ties
      quot = ((offset << 31) + (span >> 1)) / span;
      clip = 1'b0;
      if (!below) begin
         if (quot > {32'd0, Q31_MAX}) begin
            clip = 1'b1;
            return Q31_MAX;
         end
         return quot[31:0];
      end
      return 32'd0 - quot[31:0];
   endfunction

   function automatic logic [31:0] float_to_q31(input logic [31:0] raw, output logic clip);
      logic [7:0]  expo;
      logic [22:0] frac;
      logic [31:0] sig;
      logic [31:0] mag;
      int          shift;
      expo = raw[30:23];
      frac = raw[22:0];
      sig  = {8'd0, 1'b1, frac};
      clip = 1'b0;
      if (expo == EXP_SPECIAL && frac != 23'd0) return 32'd0;
      if (expo == 8'd0) return 32'd0;
      if (expo >= EXP_ONE) begin
         if (raw[31] && expo == EXP_ONE && frac == 23'd0) return Q31_MIN;
         clip = 1'b1;
         return raw[31] ? Q31_MIN : Q31_MAX;
      end
      if (expo >= EXP_ALIGN) begin
         mag = sig << (expo - EXP_ALIGN);
      end else begin
         shift = int'(EXP_ALIGN) - int'(expo);
         mag = (shift >= 24) ? 32'd0 : (sig >> shift);
      end
      return raw[31] ? 32'd0 - mag : mag;
   endfunction

   // one accepted byte: either held, or it completes a sample
   function automatic void gather_byte(input logic [7:0] b);
      int              nbytes;
      int              pos;
      logic [7:0]      part;
      logic [31:0]     raw;
      norm_result_type res;
      nbytes = int'(size_code) + 1;
      if (int'(held_count) + 1 < nbytes) begin
         held_bytes[8 * held_count +: 8] = b;
         held_count = held_count + 2'd1;
         return;
      end
      raw = 32'd0;
      for (int k = 0; k < nbytes; k++) begin
         part = (k == nbytes - 1) ? b : held_bytes[8 * k +: 8];
         pos  = big_end ? nbytes - 1 - k : k;
         raw[8 * pos +: 8] = part;
      end
      held_count = 2'd0;
      held_bytes = 24'd0;
      res.clip = 1'b0;
      case (kind)
         KIND_UNKNOWN: return;
         KIND_SIGNED: res.sample = raw << (32 - 8 * nbytes);
         KIND_FLOAT: begin
            if (nbytes == 4) res.sample = float_to_q31(raw, res.clip);
            else res.sample = unsigned_to_q31(raw, nbytes, res.clip);
         end
         default: res.sample = unsigned_to_q31(raw, nbytes, res.clip);
      endcase
      expected_samples.insert(expected_samples.size(), res);
   endfunction

   always @(posedge clock) begin
      norm_result_type want;
      if (reset) begin
         size_code  = RESET_SAMPLE_BYTES;
         kind       = KIND_SIGNED;
         big_end    = 1'b0;
         held_count = 2'd0;
         held_bytes = 24'd0;
         expected_samples.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result transfer with nothing expected: sample %h clip %b",
                           $time, rsp_norm_sample, rsp_clipped);
            end else begin
               want = expected_samples.pop_front();
               if (want.sample !== rsp_norm_sample || want.clip !== rsp_clipped) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: sample mismatch: expected %h clip %b, got %h clip %b",
                              $time, want.sample, want.clip, rsp_norm_sample, rsp_clipped);
               end
            end
         end
         // a byte in the same cycle as a register write still sees the old setting
         if (req_valid && !req_stall) gather_byte(req_stream_byte);
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SAMPLE_BYTES: size_code = csr_wr_data;
               CSR_SAMPLE_KIND:  kind = kind_type'(csr_wr_data);
               CSR_BIG_ENDIAN:   big_end = csr_wr_data[0];
               default: ;
            endcase
         end
      end
      pending <= expected_samples.size();
   end

endmodule

### test/tb_top.sv
// top of the pcm byte stream normaliser bench: clock, reset, byte and register stimulus
// depends on pcmbsn_pkg, pcm_byte_stream_normalizer and pcmbsn_sample_checker
module tb_top;
   import pcmbsn_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_BYTES = 300;
   // no register sits at this index, writes to it must be ignored
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_stream_byte = 8'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_norm_sample;
   logic               rsp_clipped;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = 2'd0;
   logic [1:0]         csr_wr_data = 2'd0;

   int       mismatches;
   int       pending;
   int       cycles = 0;
   int       send_idle_pct = 0;
   int       stall_pct = 0;
   logic     drain = 1'b0;
   int       bytes_sent = 0;
   int       cur_nbytes = 2;
   kind_type cur_kind = KIND_SIGNED;
   logic     cur_be = 1'b0;

   pcm_byte_stream_normalizer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_norm_sample (rsp_norm_sample),
      .rsp_clipped     (rsp_clipped),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   pcmbsn_sample_checker sample_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_norm_sample (rsp_norm_sample),
      .rsp_clipped     (rsp_clipped),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .mismatches      (mismatches),
      .pending         (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !drain && ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // bytes go out in stream order for the current endianness
   task automatic send_sample(input logic [31:0] word);
      int idx;
      for (int k = 0; k < cur_nbytes; k++) begin
         idx = cur_be ? cur_nbytes - 1 - k : k;
         send_byte(word[8 * idx +: 8]);
      end
   endtask

   // hold the sender until every expected sample is back, then let the pipe empty
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      drain <= 1'b1;
      repeat (6) @(posedge clock);
   endtask

   task automatic set_mode(input logic [1:0] size, input kind_type kind, input logic be,
                           input bit poke_spare);
      quiesce();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_SAMPLE_BYTES;
      csr_wr_data <= size;
      @(posedge clock);
      csr_index   <= CSR_SAMPLE_KIND;
      csr_wr_data <= kind;
      @(posedge clock);
      csr_index   <= CSR_BIG_ENDIAN;
      csr_wr_data <= {1'($urandom_range(0, 1)), be};
      @(posedge clock);
      if (poke_spare) begin
         csr_index   <= CSR_SPARE;
         csr_wr_data <= 2'($urandom_range(0, 3));
         @(posedge clock);
      end
      csr_wr_en  <= 1'b0;
      drain      <= 1'b0;
      cur_nbytes = int'(size) + 1;
      cur_kind   = kind;
      cur_be     = be;
   endtask

   // random word biased towards range ends and float landmarks
   function automatic logic [31:0] pick_sample();
      logic [31:0] w;
      int          sel;
      w   = $urandom;
      sel = $urandom_range(0, 9);
      if (cur_kind == KIND_FLOAT && cur_nbytes == 4) begin
         case (sel)
            0: w[30:23] = 8'd0;
            1: w[30:23] = EXP_SPECIAL;
            2: w[30:23] = EXP_ONE;
            3: w[30:23] = 8'($urandom_range(128, 254));
            4: w[30:23] = 8'($urandom_range(1, 110));
            default: w[30:23] = 8'($urandom_range(111, 126));
         endcase
         if (sel <= 2 && $urandom_range(0, 1) == 0) w[22:0] = 23'd0;
      end else begin
         case (sel)
            0: w = 32'd0;
            1: w = '1;
            2: w = 32'd1 << (8 * cur_nbytes - 1);
            3: w = (32'd1 << (8 * cur_nbytes - 1)) - 32'd1;
            default: ;
         endcase
      end
      return w;
   endfunction

   initial begin
      int       phase_start;
      kind_type kind;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults after reset: 16-bit little-endian signed
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'h7F);
      // unsigned bytes: minus one, saturating top code, mid code
      set_mode(SIZE_8, KIND_UNSIGNED, 1'b0, 1'b1);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      set_mode(SIZE_8, KIND_SIGNED, 1'b1, 1'b0);
      send_byte(8'h7F);
      send_byte(8'h80);
      // float: exact minus one, infinity, nan
      set_mode(SIZE_32, KIND_FLOAT, 1'b1, 1'b0);
      send_sample(32'hBF80_0000);
      send_sample(32'h7F80_0000);
      send_sample(32'h7FC0_0001);
      set_mode(SIZE_8, KIND_UNKNOWN, 1'b0, 1'b0);
      send_byte(8'h5A);
      // size shrunk with two bytes held: the next byte closes the sample
      set_mode(SIZE_24, KIND_UNSIGNED, 1'b0, 1'b0);
      send_byte(8'h12);
      send_byte(8'h34);
      set_mode(SIZE_16, KIND_UNSIGNED, 1'b0, 1'b0);
      send_byte(8'hAB);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct    <= 0;
            end
            1: begin
               send_idle_pct = 51;
               stall_pct    <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct    <= 51;
            end
            default: begin
               send_idle_pct = 32;
               stall_pct    <= 32;
            end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            if ($urandom_range(0, 9) == 0) kind = KIND_UNKNOWN;
            else kind = kind_type'($urandom_range(0, 2));
            set_mode(2'($urandom_range(0, 3)), kind, 1'($urandom_range(0, 1)),
                     $urandom_range(0, 7) == 0);
            repeat ($urandom_range(3, 20)) send_sample(pick_sample());
            // stray bytes can leave a partial sample across the next register change
            if ($urandom_range(0, 4) == 0)
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      drain <= 1'b1;
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
